// File: hw/rtl/tagged_obstacle_frame_parser_top_defines.svh
// Assertion helpers used by the parser top-level RTL.
`ifndef TAGGED_OBSTACLE_FRAME_PARSER_TOP_DEFINES_SVH
`define TAGGED_OBSTACLE_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define TOFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define TOFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tofp_pkg.sv
package tofp_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [7:0]  TAG_NONE  = 8'd78;
  localparam logic [7:0]  TAG_START = 8'd83;
  localparam logic [7:0]  TAG_END   = 8'd69;
  localparam logic [7:0]  TAG_DIST  = 8'd68;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REPORT_OBST = 1'b0;
  localparam logic REPORT_NONE = 1'b1;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_START = 2'd1,
    MODE_END   = 2'd2,
    MODE_DIST  = 2'd3
  } mode_t;

  // What the parse stage hands on for one processed beat
  typedef struct packed {
    logic             step;
    logic             vld;
    logic             kind;
    logic             full;
    logic [IDX_W-1:0] idx;
    logic [31:0]      distance;
    logic [CNT_W-1:0] total;
    logic             st_we;
    logic             en_we;
    logic [IDX_W-1:0] waddr;
    logic [15:0]      wdata;
  } par_out_t;

endpackage

// File: hw/rtl/tofp_ram.sv
module tofp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tofp_parse.sv
module tofp_parse import tofp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  input  logic        step_en,
  output par_out_t    po
);

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_op_r;
  logic [7:0]       s1_byte_r;
  logic [8:0]       phase_r, phase_nxt;
  mode_t            mode_r, mode_nxt;
  logic [15:0]      sacc_r, sacc_nxt;
  logic [15:0]      eacc_r, eacc_nxt;
  logic [7:0]       dlen_r, dlen_nxt;
  logic [31:0]      dacc_r, dacc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [15:0]      timeout_r;

  logic             proc;
  logic             is_byte;
  logic [CNT_W-1:0] cnt_eff;
  logic             room;
  logic [8:0]       lane_k;
  logic [31:0]      dacc_new;
  logic             dist_done;
  logic [15:0]      angle_hi;

  assign proc     = s1_valid_r && step_en;
  assign in_ready = !s1_valid_r || step_en;
  assign is_byte  = proc && (s1_op_r == OP_BYTE);

  // a byte after too long a gap restarts numbering before anything else
  assign cnt_eff  = (idle_r > timeout_r) ? '0 : count_r;
  assign room     = cnt_eff < CNT_W'(TABLE_DEPTH);
  assign lane_k   = phase_r - 9'd2;
  assign dacc_new = (lane_k < 9'd4) ?
                    (dacc_r | (32'(s1_byte_r) << {lane_k[1:0], 3'b000})) : dacc_r;
  assign dist_done = (phase_r - 9'd1) >= {1'b0, dlen_r};
  assign angle_hi  = (mode_r == MODE_START) ? {s1_byte_r, sacc_r[7:0]}
                                            : {s1_byte_r, eacc_r[7:0]};

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    sacc_nxt  = sacc_r;
    eacc_nxt  = eacc_r;
    dlen_nxt  = dlen_r;
    dacc_nxt  = dacc_r;
    count_nxt = count_r;
    idle_nxt  = idle_r;
    if (proc && (s1_op_r == OP_TICK)) begin
      if (idle_r != IDLE_MAX) begin
        idle_nxt = idle_r + 16'd1;
      end
    end else if (is_byte) begin
      idle_nxt  = '0;
      count_nxt = cnt_eff;
      priority if (phase_r == 9'd0) begin
        priority if (s1_byte_r == TAG_NONE) begin
          mode_nxt = MODE_NONE;
        end else if (s1_byte_r == TAG_START) begin
          mode_nxt = MODE_START; phase_nxt = 9'd1;
        end else if (s1_byte_r == TAG_END) begin
          mode_nxt = MODE_END; phase_nxt = 9'd1;
        end else if (s1_byte_r == TAG_DIST) begin
          mode_nxt = MODE_DIST; phase_nxt = 9'd1;
        end else begin
          mode_nxt = mode_r;
        end
      end else if (phase_r == 9'd1) begin
        phase_nxt = 9'd2;
        unique case (mode_r)
          MODE_START: sacc_nxt = {8'd0, s1_byte_r};
          MODE_END:   eacc_nxt = {8'd0, s1_byte_r};
          MODE_DIST:  dlen_nxt = s1_byte_r;
          MODE_NONE:  phase_nxt = 9'd0;
        endcase
      end else if (phase_r == 9'd2) begin
        unique case (mode_r)
          MODE_START: begin
            sacc_nxt = angle_hi; mode_nxt = MODE_NONE; phase_nxt = 9'd0;
          end
          MODE_END: begin
            eacc_nxt = angle_hi; mode_nxt = MODE_NONE; phase_nxt = 9'd0;
          end
          MODE_DIST: begin
            dacc_nxt = 32'(s1_byte_r); phase_nxt = 9'd3;
          end
          MODE_NONE: phase_nxt = 9'd0;
        endcase
      end else begin
        if (mode_r != MODE_DIST) begin
          phase_nxt = 9'd0;
        end else begin
          dacc_nxt = dacc_new;
          if (!dist_done) begin
            phase_nxt = phase_r + 9'd1;
          end else begin
            mode_nxt  = MODE_NONE;
            phase_nxt = 9'd0;
            if (room) begin
              count_nxt = cnt_eff + CNT_W'(1);
            end
          end
        end
      end
    end
  end

  // report and table write for this beat
  always_comb begin
    po       = '0;
    po.step  = proc;
    po.waddr = cnt_eff[IDX_W-1:0];
    po.wdata = angle_hi;
    if (is_byte) begin
      priority if (phase_r == 9'd0) begin
        if (s1_byte_r == TAG_NONE) begin
          po.vld   = 1'b1;
          po.kind  = REPORT_NONE;
          po.total = cnt_eff;
        end
      end else if (phase_r == 9'd2) begin
        po.st_we = room && (mode_r == MODE_START);
        po.en_we = room && (mode_r == MODE_END);
      end else if (phase_r != 9'd1) begin
        if ((mode_r == MODE_DIST) && dist_done) begin
          po.vld      = 1'b1;
          po.kind     = REPORT_OBST;
          po.distance = dacc_new;
          po.full     = !room;
          if (room) begin
            po.idx   = cnt_eff[IDX_W-1:0];
            po.total = cnt_eff + CNT_W'(1);
          end else begin
            po.total = cnt_eff;
          end
        end
      end else begin
        po.vld = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= '0;
      mode_r     <= MODE_NONE;
      sacc_r     <= '0;
      eacc_r     <= '0;
      dlen_r     <= '0;
      dacc_r     <= '0;
      count_r    <= '0;
      idle_r     <= '0;
      timeout_r  <= TIMEOUT_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
      mode_r     <= mode_nxt;
      sacc_r     <= sacc_nxt;
      eacc_r     <= eacc_nxt;
      dlen_r     <= dlen_nxt;
      dacc_r     <= dacc_nxt;
      count_r    <= count_nxt;
      idle_r     <= idle_nxt;
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_opcode;
      s1_byte_r <= in_rx_byte;
    end
  end

endmodule

// File: hw/rtl/tagged_obstacle_frame_parser_top.sv
// A beat is registered in the parse stage, then the read stage, then the output register on out_*.
// Throughput: one byte or tick per cycle; the parse stage stalls only when a
// report waits in the read stage and the output register is held.
// Table angles come from two registered-read RAMs read in the parse cycle.
// Reset (rst_n low at a clock edge): parser state, count and idle counter cleared,
// timeout 500 ms; then every entry of both tables is zeroed, with in_ready low meanwhile.
`include "tagged_obstacle_frame_parser_top_defines.svh"

module tagged_obstacle_frame_parser_top import tofp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_report_kind,
  output logic [7:0]  out_entry_index,
  output logic [15:0] out_start_angle,
  output logic [15:0] out_end_angle,
  output logic [31:0] out_distance,
  output logic        out_table_full,
  output logic [8:0]  out_obstacle_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  par_out_t         po;
  logic             en2, en3;
  logic [15:0]      st_rdata, en_rdata;
  logic             p_in_ready;

  logic             clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0] clr_addr_r, clr_addr_nxt;
  logic             st_we, en_we;
  logic [IDX_W-1:0] tab_waddr;
  logic [15:0]      tab_wdata;

  logic             s2_valid_r, s2_valid_nxt;
  logic             s2_kind_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [31:0]      s2_dist_r;
  logic             s2_full_r;
  logic [CNT_W-1:0] s2_total_r;
  logic             s2_tab_ok_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r;
  logic [7:0]       out_idx_r;
  logic [15:0]      out_start_r, out_end_r;
  logic [31:0]      out_dist_r;
  logic             out_full_r;
  logic [8:0]       out_total_r;

  assign en3 = !out_valid_r || out_ready;
  assign en2 = !s2_valid_r || en3;
  assign cfg_ready = 1'b1;
  assign in_ready  = p_in_ready && !clr_busy_r;

  tofp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid && !clr_busy_r),
    .in_ready   (p_in_ready),
    .in_opcode  (in_opcode),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .step_en    (en2),
    .po         (po)
  );

  // zero both tables one entry at a time, in address order, after reset; hold input off meanwhile
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + IDX_W'(1);
      if (clr_addr_r == IDX_W'(TABLE_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  assign st_we     = clr_busy_r || po.st_we;
  assign en_we     = clr_busy_r || po.en_we;
  assign tab_waddr = clr_busy_r ? clr_addr_r : po.waddr;
  assign tab_wdata = clr_busy_r ? 16'd0 : po.wdata;

  tofp_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (po.step),
    .raddr (po.idx),
    .rdata (st_rdata)
  );

  tofp_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_end_ram (
    .clk   (clk),
    .we    (en_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (po.step),
    .raddr (po.idx),
    .rdata (en_rdata)
  );

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (po.step) begin
      s2_valid_nxt = po.vld;
    end else if (en3) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en3) begin
      out_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
    end
  end

  // RAM data lands alongside the read-stage record; mask it on reports with no entry
  always_ff @(posedge clk) begin
    if (po.step) begin
      s2_kind_r   <= po.kind;
      s2_idx_r    <= po.idx;
      s2_dist_r   <= po.distance;
      s2_full_r   <= po.full;
      s2_total_r  <= po.total;
      s2_tab_ok_r <= po.vld && (po.kind == REPORT_OBST) && !po.full;
    end
    if (en3 && s2_valid_r) begin
      out_kind_r  <= s2_kind_r;
      out_idx_r   <= 8'(s2_idx_r);
      out_start_r <= s2_tab_ok_r ? st_rdata : 16'd0;
      out_end_r   <= s2_tab_ok_r ? en_rdata : 16'd0;
      out_dist_r  <= s2_dist_r;
      out_full_r  <= s2_full_r;
      out_total_r <= 9'(s2_total_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_kind    = out_kind_r;
  assign out_entry_index    = out_idx_r;
  assign out_start_angle    = out_start_r;
  assign out_end_angle      = out_end_r;
  assign out_distance       = out_dist_r;
  assign out_table_full     = out_full_r;
  assign out_obstacle_total = out_total_r;

  `TOFP_ASSERT_NOW(a_none_report_clean,
    out_valid && (out_report_kind == REPORT_NONE),
    (out_entry_index == 8'd0) && (out_start_angle == 16'd0) &&
    (out_end_angle == 16'd0) && (out_distance == 32'd0) && !out_table_full,
    "no-obstacle report carries record data")
  `TOFP_ASSERT_NOW(a_full_report_clean,
    out_valid && out_table_full,
    (out_report_kind == REPORT_OBST) && (out_entry_index == 8'd0) &&
    (out_start_angle == 16'd0) && (out_end_angle == 16'd0),
    "dropped record carries table data")
  `TOFP_ASSERT_NOW(a_no_read_while_held,
    s2_valid_r && !en3,
    !po.step,
    "table read issued while a pending record is held")
  `TOFP_ASSERT_NEXT(a_pending_kept,
    s2_valid_r && !en3,
    s2_valid_r,
    "pending record lost while output stalled")

endmodule
